// ===== sv/touch_burst_average_mapper_unit_macros.svh =====
// assertion macros shared by the checker
`ifndef TOUCH_BURST_AVERAGE_MAPPER_UNIT_MACROS_SVH
`define TOUCH_BURST_AVERAGE_MAPPER_UNIT_MACROS_SVH

// property checked on every clock outside reset
`define TBAM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every clock, reset included
`define TBAM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/tbam_pkg.sv =====
// constants and arithmetic helpers for the touch burst mapper
package tbam_pkg;

  localparam int unsigned BURST_LEN = 10;
  localparam logic [15:0] RAW_LIMIT = 16'd4096;
  localparam logic [15:0] OFFSET    = 16'd512;
  localparam logic [15:0] SPAN      = 16'd1024;

  // x / 10 == (x * 52429) >> 19 for every 16-bit x
  localparam logic [15:0] DIV10_MUL   = 16'd52429;
  localparam int unsigned DIV10_SHIFT = 19;

  // register index of swap_axes
  localparam logic REG_SWAP_AXES = 1'b0;

  function automatic logic [15:0] div10(input logic [15:0] v);
    logic [31:0] p;
    p = 32'(v) * 32'(DIV10_MUL);
    return 16'(p >> DIV10_SHIFT);
  endfunction

  // remove offset with floor at zero, then scale by 10/32
  function automatic logic [15:0] scale_axis(input logic [15:0] s);
    logic [15:0] d;
    logic [19:0] m;
    d = (s > OFFSET) ? (s - OFFSET) : 16'd0;
    m = {d, 3'b000} + {1'b0, d, 1'b0};
    return m[19:5] == 15'd0 ? 16'd0 : {1'b0, m[19:5]};
  endfunction

endpackage

// ===== sv/touch_burst_average_mapper_unit.sv =====
// touch burst average mapper top level
// Usage: the input channel (in_valid/in_ready) carries one poll word per
// item: sample_ok, x_raw, y_raw, pen_up. Polls with a reading add to the
// running burst sums; a burst closes on the tenth reading or on pen_up and
// then yields one result word (touched, x_pos, y_pos) on the output channel
// (out_valid/out_ready). Polls that do not close a burst yield no word.
// Path: a closing poll, once accepted, passes the input register, the
// accumulate stage and the mapping stage before its result word shows.
// Throughput: one poll per cycle while no output stall holds the pipeline;
// the accumulate stage is the only loop.
// Stall: when out_ready is low the result word holds; polls that close no
// burst still flow into the sums, and once a second closing poll sits in the
// closed burst register one more poll is taken into the input register, then
// in_ready drops.
// Reset (rst, synchronous): empties the pipeline, clears the burst state and
// clears swap_axes. swap_axes is written through the APB port when paddr[2]
// is clear and should only change while no poll is in flight.
module touch_burst_average_mapper_unit
  import tbam_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        sample_ok,
  input  logic [15:0] x_raw,
  input  logic [15:0] y_raw,
  input  logic        pen_up,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        touched,
  output logic [15:0] x_pos,
  output logic [15:0] y_pos,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic swap_axes;

  // burst state
  logic [3:0]  sample_count;
  logic [15:0] horiz_sum;
  logic [15:0] vert_sum;
  logic        burst_bad;

  // input register
  logic        s1_valid;
  logic        s1_ok;
  logic [15:0] s1_x;
  logic [15:0] s1_y;
  logic        s1_pen;

  // closed burst register
  logic        e_valid;
  logic        e_full;
  logic [15:0] e_horiz;
  logic [15:0] e_vert;

  logic out_en, e_move, s1_take, s1_load;

  logic [3:0]  count_next;
  logic [15:0] horiz_next, vert_next;
  logic        bad_next, burst_end;

  logic [15:0] map_h, map_v, map_x, map_y;
  logic        map_touched;

  // config port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      swap_axes <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_SWAP_AXES) begin
      swap_axes <= pwdata[0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_SWAP_AXES) begin
      prdata = {31'd0, swap_axes};
    end
  end

  // stage flow
  assign out_en   = !out_valid || out_ready;
  assign e_move   = !e_valid || out_en;
  assign s1_take  = s1_valid && e_move;
  assign s1_load  = !s1_valid || s1_take;
  assign in_ready = s1_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_ok  <= sample_ok;
      s1_x   <= x_raw;
      s1_y   <= y_raw;
      s1_pen <= pen_up;
    end
  end

  // accumulate
  always_comb begin
    horiz_next = horiz_sum;
    vert_next  = vert_sum;
    count_next = sample_count;
    bad_next   = burst_bad;
    if (s1_ok) begin
      horiz_next = horiz_sum + div10(s1_y);
      vert_next  = vert_sum + div10(s1_x);
      count_next = sample_count + 4'd1;
      bad_next   = burst_bad || (s1_x > RAW_LIMIT) || (s1_y > RAW_LIMIT);
    end
    burst_end = s1_pen || (count_next >= 4'(BURST_LEN));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= 4'd0;
      horiz_sum    <= 16'd0;
      vert_sum     <= 16'd0;
      burst_bad    <= 1'b0;
    end else if (s1_take) begin
      if (burst_end) begin
        sample_count <= 4'd0;
        horiz_sum    <= 16'd0;
        vert_sum     <= 16'd0;
        burst_bad    <= 1'b0;
      end else begin
        sample_count <= count_next;
        horiz_sum    <= horiz_next;
        vert_sum     <= vert_next;
        burst_bad    <= bad_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (e_move) begin
      e_valid <= s1_take && burst_end;
    end
  end

  always_ff @(posedge clk) begin
    if (e_move) begin
      e_full  <= (count_next >= 4'(BURST_LEN)) && !bad_next;
      e_horiz <= horiz_next;
      e_vert  <= vert_next;
    end
  end

  // mapping
  always_comb begin
    map_h = scale_axis(e_horiz);
    map_v = scale_axis(RAW_LIMIT - e_vert);
    if (swap_axes) begin
      map_x = SPAN - map_v;
      map_y = SPAN - map_h;
    end else begin
      map_x = map_h;
      map_y = map_v;
    end
    map_touched = !((map_x > SPAN) || (map_y > SPAN));
    if (!e_full) begin
      map_x       = 16'd0;
      map_y       = 16'd0;
      map_touched = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_en) begin
      out_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      touched <= map_touched;
      x_pos   <= map_x;
      y_pos   <= map_y;
    end
  end

endmodule

// ===== sv/tbam_checker.sv =====
// port-level checker for the touch burst mapper, with its bind
`include "touch_burst_average_mapper_unit_macros.svh"

module tbam_checker
  import tbam_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        touched,
  input logic [15:0] x_pos,
  input logic [15:0] y_pos,
  input logic        pready
);

  logic        out_stall;
  logic [32:0] out_word;
  logic        pos_in_window;
  logic        miss_word;

  assign out_stall     = out_valid && !out_ready;
  assign out_word      = {touched, x_pos, y_pos};
  assign pos_in_window = (x_pos <= SPAN) && (y_pos <= SPAN);
  // untouched word that carries coordinates
  assign miss_word     = out_valid && !touched && (x_pos != 16'd0 || y_pos != 16'd0);

  // a stalled word holds
  `TBAM_ASSERT(a_out_hold, out_stall |=> out_valid && $stable(out_word), "stalled word moved")

  // a touch always lies inside the window
  `TBAM_ASSERT(a_touch_in_window, out_valid && touched |-> pos_in_window, "touch outside window")

  // nonzero coordinates without touch only come from an out-of-window burst
  `TBAM_ASSERT(a_untouched_coords, miss_word |-> !pos_in_window, "untouched word in window")

  // nothing is offered right after reset
  `TBAM_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result word present after reset")

  // config port never waits
  `TBAM_ASSERT_ALWAYS(a_pready, pready, "pready low")

endmodule

bind touch_burst_average_mapper_unit tbam_checker u_tbam_checker (.*);

// ===== tb/touch_burst_average_mapper_unit_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the touch burst average mapper unit
module touch_burst_average_mapper_unit_tb;
  import tbam_pkg::*;

  localparam int POLLS_PER_PHASE = 400;
  localparam int DRAIN_CYCLES = 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [2:0] SWAP_AXES_ADDR = {REG_SWAP_AXES, 2'b00};

  typedef struct packed {
    logic        touched;
    logic [15:0] x_pos;
    logic [15:0] y_pos;
  } touch_word_t;

  localparam touch_word_t NO_TOUCH = '0;

  typedef enum {ROW_MODEL, ROW_NO_WORD, ROW_FIXED_WORD} row_check_t;

  typedef struct {
    logic        ok;
    logic [15:0] xr;
    logic [15:0] yr;
    logic        pen;
    int          reps;
    row_check_t  check;
    touch_word_t word;
  } poll_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        sample_ok;
  logic [15:0] x_raw;
  logic [15:0] y_raw;
  logic        pen_up;
  logic        out_valid;
  logic        out_ready;
  logic        touched;
  logic [15:0] x_pos;
  logic [15:0] y_pos;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // burst state as the block should hold it
  logic [3:0]  readings = '0;
  logic [15:0] horiz_acc = '0;
  logic [15:0] vert_acc = '0;
  logic        bad_burst = 1'b0;
  logic        swap_setting = 1'b0;

  touch_word_t pending_words[$];
  int          mismatch_count = 0;
  int          polls_sent = 0;
  bit          steady = 1'b0;

  // the reps column repeats a poll; a typed word belongs to the last repeat
  poll_row_t directed_polls [11] = '{
    '{1'b0, 16'd0,     16'd0,     1'b1, 1, ROW_FIXED_WORD, NO_TOUCH},
    '{1'b0, 16'hFFFF,  16'hFFFF,  1'b0, 1, ROW_NO_WORD,    NO_TOUCH},
    '{1'b1, 16'hFFFF,  16'hFFFF,  1'b0, 9, ROW_MODEL,      NO_TOUCH},
    '{1'b1, 16'd4097,  16'd0,     1'b0, 1, ROW_FIXED_WORD, NO_TOUCH},
    '{1'b1, 16'd4096,  16'd4096,  1'b0, 9, ROW_NO_WORD,    NO_TOUCH},
    '{1'b1, 16'd4096,  16'd4096,  1'b1, 1, ROW_MODEL,      NO_TOUCH},
    '{1'b1, 16'd0,     16'd4097,  1'b0, 5, ROW_NO_WORD,    NO_TOUCH},
    '{1'b0, 16'd0,     16'd0,     1'b1, 1, ROW_FIXED_WORD, NO_TOUCH},
    '{1'b1, 16'd700,   16'd3790,  1'b0, 9, ROW_MODEL,      NO_TOUCH},
    '{1'b0, 16'h5A5A,  16'hA5A5,  1'b0, 1, ROW_NO_WORD,    NO_TOUCH},
    '{1'b1, 16'd700,   16'd3790,  1'b0, 1, ROW_MODEL,      NO_TOUCH}
  };

  touch_burst_average_mapper_unit uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample_ok (sample_ok),
    .x_raw     (x_raw),
    .y_raw     (y_raw),
    .pen_up    (pen_up),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .touched   (touched),
    .x_pos     (x_pos),
    .y_pos     (y_pos),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // offset removal with floor, then 10/32 scaling
  function automatic logic [15:0] squeeze_axis(input logic [15:0] s);
    logic [31:0] d;
    d = (s > OFFSET) ? 32'(s - OFFSET) : 32'd0;
    return 16'((d * 32'd10) >> 5);
  endfunction

  // takes one accepted poll, returns 1 when it closes the burst
  function automatic bit advance_burst(input logic ok, input logic [15:0] xr,
                                       input logic [15:0] yr, input logic pen,
                                       output touch_word_t w);
    logic [15:0] h;
    logic [15:0] v;
    w = NO_TOUCH;
    if (ok) begin
      horiz_acc = horiz_acc + yr / 16'd10;
      vert_acc = vert_acc + xr / 16'd10;
      if (xr > RAW_LIMIT || yr > RAW_LIMIT) bad_burst = 1'b1;
      readings = readings + 4'd1;
    end
    if (!pen && readings < BURST_LEN) return 1'b0;
    if (!(readings < BURST_LEN) && !bad_burst) begin
      h = squeeze_axis(horiz_acc);
      v = squeeze_axis(RAW_LIMIT - vert_acc);
      if (swap_setting) begin
        w.x_pos = SPAN - v;
        w.y_pos = SPAN - h;
      end else begin
        w.x_pos = h;
        w.y_pos = v;
      end
      w.touched = !(w.x_pos > SPAN || w.y_pos > SPAN);
    end
    readings = '0;
    horiz_acc = '0;
    vert_acc = '0;
    bad_burst = 1'b0;
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [15:0] pick_raw();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return 16'd0;
    if (r < 12) return RAW_LIMIT;
    if (r < 30) return 16'($urandom_range(1000, 3500));
    return 16'($urandom_range(0, 4096));
  endfunction

  function automatic logic [15:0] pick_bad_raw();
    if ($urandom_range(0, 7) == 0) return 16'hFFFF;
    return 16'($urandom_range(4097, 65535));
  endfunction

  task automatic report(input string what, input int got, input int want);
    mismatch_count++;
    $display("%0t mismatch %s: got %0h, want %0h", $time, what, got, want);
  endtask

  task automatic send_poll(input logic ok, input logic [15:0] xr, input logic [15:0] yr,
                           input logic pen, output bit has_word, output touch_word_t w);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_ok <= ok;
    x_raw <= xr;
    y_raw <= yr;
    pen_up <= pen;
    do @(posedge clk); while (!in_ready);
    has_word = advance_burst(ok, xr, yr, pen, w);
    // polls that change nothing are not counted
    if (ok || pen) polls_sent++;
  endtask

  task automatic feed_poll(input logic ok, input logic [15:0] xr, input logic [15:0] yr,
                           input logic pen);
    bit          has_word;
    touch_word_t w;
    send_poll(ok, xr, yr, pen, has_word, w);
    if (has_word) pending_words.push_back(w);
  endtask

  task automatic random_burst();
    int kind;
    int n;
    int bad_at;
    int which;
    logic [15:0] xr;
    logic [15:0] yr;
    kind = $urandom_range(0, 99);
    steady = ($urandom_range(0, 6) == 0);
    if (kind < 65) begin
      for (int i = 0; i < 10; i++) begin
        if ($urandom_range(0, 9) == 0)
          feed_poll(1'b0, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), 1'b0);
        feed_poll(1'b1, pick_raw(), pick_raw(), (i == 9) && ($urandom_range(0, 1) == 1));
      end
    end else if (kind < 75) begin
      // pen lifted on or before the tenth reading
      n = $urandom_range(0, 9);
      for (int i = 0; i < n; i++) feed_poll(1'b1, pick_raw(), pick_raw(), 1'b0);
      feed_poll(1'($urandom_range(0, 1)), pick_raw(), pick_raw(), 1'b1);
    end else if (kind < 87) begin
      bad_at = $urandom_range(0, 9);
      which = $urandom_range(0, 2);
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(bad_at + 1, 10) : 10;
      for (int i = 0; i < n; i++) begin
        xr = (i == bad_at && which != 1) ? pick_bad_raw() : pick_raw();
        yr = (i == bad_at && which != 0) ? pick_bad_raw() : pick_raw();
        feed_poll(1'b1, xr, yr, (i == n - 1) && (n < 10));
      end
    end else begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++)
        feed_poll(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)), $urandom_range(0, 3) == 0);
    end
    steady = 1'b0;
  endtask

  task automatic finish_phase();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    // polls without a word may still be in the pipe
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_swap(input logic v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= SWAP_AXES_ADDR;
    pwdata <= {31'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    swap_setting = v;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {31'd0, swap_setting}) report("swap_axes readback", prdata, swap_setting);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin : result_ready
    int hold;
    forever begin
      out_ready <= 1'b1;
      hold = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 6);
      repeat (hold) @(posedge clk);
      hold = pick_gap();
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : word_check
    touch_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        report("unexpected word", int'({x_pos, y_pos}), 0);
      end else begin
        want = pending_words.pop_front();
        if (touched !== want.touched) report("touched", touched, want.touched);
        if (x_pos !== want.x_pos) report("x_pos", x_pos, want.x_pos);
        if (y_pos !== want.y_pos) report("y_pos", y_pos, want.y_pos);
      end
    end
  end

  // ends the run when no word moves on either side for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    bit          has_word;
    touch_word_t w;
    rst <= 1'b1;
    in_valid <= 1'b0;
    sample_ok <= 1'b0;
    x_raw <= '0;
    y_raw <= '0;
    pen_up <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_polls[r]) begin
      for (int k = 1; k <= directed_polls[r].reps; k++) begin
        send_poll(directed_polls[r].ok, directed_polls[r].xr, directed_polls[r].yr,
                  directed_polls[r].pen, has_word, w);
        case (directed_polls[r].check)
          ROW_MODEL: begin
            if (has_word) pending_words.push_back(w);
          end
          ROW_FIXED_WORD: begin
            if (k == directed_polls[r].reps) pending_words.push_back(directed_polls[r].word);
          end
          default: ;
        endcase
      end
    end
    finish_phase();

    // swap on, off, on, off
    for (int p = 0; p < 4; p++) begin
      write_swap(p % 2 == 0);
      polls_sent = 0;
      while (polls_sent < POLLS_PER_PHASE) random_burst();
      finish_phase();
    end

    if (pending_words.size() != 0) report("words never seen", pending_words.size(), 0);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
